@@ design/brop_pkg.sv @@
package brop_pkg;

    // Display geometry.
    localparam int DISPLAY_WIDTH = 128;
    localparam int PAGE_ROWS     = 8;
    localparam int NUM_GROUPS    = DISPLAY_WIDTH / 8;

    // Field widths.
    localparam int PIXEL_W   = 8;
    localparam int GROUP_W   = 64;
    localparam int INDEX_W   = 4;
    localparam int PAGE_W    = 3;
    localparam int STORE_W   = 56;
    localparam int RB_W      = 5;
    localparam int IH_W      = 7;
    localparam int PL_W      = 4;
    localparam int ROW_W     = 3;
    localparam int PCOUNT_W  = 4;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_ROW_BYTES    = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PAGE_LIMIT   = 2'd2;
    localparam logic [1:0] REG_START_PAGE   = 2'd3;

    localparam logic [RB_W-1:0]   ROW_BYTES_RESET    = RB_W'(NUM_GROUPS);
    localparam logic [IH_W-1:0]   IMAGE_HEIGHT_RESET = IH_W'(64);
    localparam logic [PL_W-1:0]   PAGE_LIMIT_RESET   = PL_W'(8);
    localparam logic [PAGE_W-1:0] START_PAGE_RESET   = PAGE_W'(7);

    localparam logic [INDEX_W-1:0] LAST_GROUP = INDEX_W'(NUM_GROUPS - 1);

    // Row r of the input, bit (7-j), becomes column j, bit (7-r).
    function automatic logic [GROUP_W-1:0] transpose(input logic [GROUP_W-1:0] rows);
        logic [GROUP_W-1:0] res;
        res = '0;
        for (int j = 0; j < 8; j++) begin
            for (int r = 0; r < 8; r++) begin
                res[8*j + (7-r)] = rows[8*r + (7-j)];
            end
        end
        return res;
    endfunction

endpackage

@@ design/bitmap_rows_to_oled_pages_top.sv @@
// A result is registered and appears on the m_ side in the cycle after the pixel byte request that causes it.
// Throughput: one pixel byte per cycle while the output slot is free; after the last byte k of a row that
// completes a page, input is held off while zero groups k+1..NUM_GROUPS-1 are sent.
// Reset (aresetn low, synchronous) returns the registers to their defaults, empties the row
// store through its valid bits, clears all counters and the output valid flag, and holds
// s_tready low.
module bitmap_rows_to_oled_pages_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream, tdata: pixel_byte[7:0].
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,
    // Result stream, tdata: column_group[63:0].
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [63:0]                        m_tdata,
    // tuser: group_index[3:0], page[6:4].
    output logic [6:0]                         m_tuser,
    // tlast carries page_last.
    output logic                               m_tlast,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [brop_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [brop_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [brop_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import brop_pkg::*;

    // Configuration registers, kept unsaturated as written (field bits only) so that reads return them.
    logic [RB_W-1:0]   row_bytes_reg;
    logic [IH_W-1:0]   image_height_reg;
    logic [PL_W-1:0]   page_limit_reg;
    logic [PAGE_W-1:0] start_page_reg;

    // Row store: rows 0..6 of the current page, one entry per byte position in the row.
    // An entry whose valid bit is clear reads as zero, so clearing the valid bits empties the whole
    // store at the end of a page.
    logic [STORE_W-1:0]    store_reg [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] valid_reg;

    // Position counters.
    logic [ROW_W-1:0]    row_in_page_reg;
    logic [INDEX_W-1:0]  byte_in_row_reg;
    logic [PCOUNT_W-1:0] page_count_reg;
    logic [IH_W-1:0]     rows_seen_reg;
    logic                finished_reg;

    // Zero-fill sequencer for the groups after the last byte of a flushed row.
    logic                fill_active_reg;
    logic [INDEX_W-1:0]  fill_k_reg;
    logic [PAGE_W-1:0]   fill_page_reg;

    // Output register.
    logic                m_valid_reg;
    logic [GROUP_W-1:0]  m_data_reg;
    logic [INDEX_W-1:0]  m_index_reg;
    logic [PAGE_W-1:0]   m_page_reg;
    logic                m_last_reg;

    logic cfg_write;
    logic [1:0] cfg_index;

    logic [RB_W-1:0]     rb_sat;
    logic [IH_W-1:0]     ih_sat;
    logic [PL_W-1:0]     pl_sat;
    logic                slot_free;
    logic                accept;
    logic                active;
    logic                row_end;
    logic                last_row;
    logic                flush;
    logic [STORE_W-1:0]  store_base;
    logic [GROUP_W-1:0]  shifted;
    logic [GROUP_W-1:0]  rows;
    logic [PAGE_W-1:0]   cur_page;
    logic [PCOUNT_W-1:0] page_count_next;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is tied high.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            REG_ROW_BYTES:    prdata = APB_DATA_W'(row_bytes_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
            REG_PAGE_LIMIT:   prdata = APB_DATA_W'(page_limit_reg);
            REG_START_PAGE:   prdata = APB_DATA_W'(start_page_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg    <= ROW_BYTES_RESET;
            image_height_reg <= IMAGE_HEIGHT_RESET;
            page_limit_reg   <= PAGE_LIMIT_RESET;
            start_page_reg   <= START_PAGE_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_ROW_BYTES:    row_bytes_reg    <= pwdata[RB_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[IH_W-1:0];
                REG_PAGE_LIMIT:   page_limit_reg   <= pwdata[PL_W-1:0];
                REG_START_PAGE:   start_page_reg   <= pwdata[PAGE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Out-of-range register values saturate into their legal ranges.
    always_comb begin
        rb_sat = row_bytes_reg;
        if (row_bytes_reg == '0) begin
            rb_sat = RB_W'(1);
        end else if (row_bytes_reg > RB_W'(NUM_GROUPS)) begin
            rb_sat = RB_W'(NUM_GROUPS);
        end
        ih_sat = image_height_reg;
        if (image_height_reg == '0) begin
            ih_sat = IH_W'(1);
        end else if (image_height_reg > IH_W'(64)) begin
            ih_sat = IH_W'(64);
        end
        pl_sat = page_limit_reg;
        if (page_limit_reg == '0) begin
            pl_sat = PL_W'(1);
        end else if (page_limit_reg > PL_W'(8)) begin
            pl_sat = PL_W'(8);
        end
    end

    // ------------------------------------------------------------------
    // Request decode. The output slot is free when empty or being drained this cycle;
    // input is held off during reset and while zero groups are being sent.
    // ------------------------------------------------------------------
    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = aresetn && slot_free && !fill_active_reg;
    assign accept    = s_tvalid && s_tready;

    // Once finished or past the page limit, bytes are taken and dropped.
    assign active   = !finished_reg && (page_count_reg < PCOUNT_W'(pl_sat));
    assign row_end  = ({1'b0, byte_in_row_reg} >= (rb_sat - RB_W'(1)));
    assign last_row = ({1'b0, rows_seen_reg} + 8'd1) >= {1'b0, ih_sat};
    assign flush    = (row_in_page_reg == ROW_W'(PAGE_ROWS - 1)) || last_row;

    assign store_base = valid_reg[byte_in_row_reg] ? store_reg[byte_in_row_reg] : '0;
    assign shifted    = GROUP_W'(s_tdata) << {row_in_page_reg, 3'b000};
    assign rows       = {{(GROUP_W-STORE_W){1'b0}}, store_base} | shifted;
    assign cur_page   = start_page_reg - page_count_reg[PAGE_W-1:0];
    assign page_count_next = page_count_reg + PCOUNT_W'(1);

    // ------------------------------------------------------------------
    // Row store and position counters.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept && active && !flush) begin
            store_reg[byte_in_row_reg] <= rows[STORE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            row_in_page_reg <= '0;
            byte_in_row_reg <= '0;
            page_count_reg  <= '0;
            rows_seen_reg   <= '0;
            finished_reg    <= 1'b0;
        end else if (accept && active) begin
            if (!flush) begin
                valid_reg[byte_in_row_reg] <= 1'b1;
            end
            if (row_end) begin
                byte_in_row_reg <= '0;
                rows_seen_reg   <= rows_seen_reg + IH_W'(1);
                if (flush) begin
                    valid_reg       <= '0;
                    row_in_page_reg <= '0;
                    page_count_reg  <= page_count_next;
                    if (last_row || (page_count_next >= PCOUNT_W'(pl_sat))) begin
                        finished_reg <= 1'b1;
                    end
                end else begin
                    row_in_page_reg <= row_in_page_reg + ROW_W'(1);
                end
            end else begin
                byte_in_row_reg <= byte_in_row_reg + INDEX_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Zero-fill sequencer: started by the last byte of a flushed row that is not the
    // last group of the display, it walks the remaining group indexes one per cycle while the output slot is free.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_active_reg <= 1'b0;
            fill_k_reg      <= '0;
            fill_page_reg   <= '0;
        end else if (accept) begin
            if (active && flush && row_end && (byte_in_row_reg != LAST_GROUP)) begin
                fill_active_reg <= 1'b1;
                fill_k_reg      <= byte_in_row_reg + INDEX_W'(1);
                fill_page_reg   <= cur_page;
            end
        end else if (fill_active_reg && slot_free) begin
            if (fill_k_reg == LAST_GROUP) begin
                fill_active_reg <= 1'b0;
            end else begin
                fill_k_reg <= fill_k_reg + INDEX_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register. A flushed byte loads a transposed group; the sequencer loads
    // zero groups. The two never compete because input is held off during a fill.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && active && flush) begin
            m_valid_reg <= 1'b1;
        end else if (fill_active_reg && slot_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && active && flush) begin
            m_data_reg  <= transpose(rows);
            m_index_reg <= byte_in_row_reg;
            m_page_reg  <= cur_page;
            m_last_reg  <= row_end && (byte_in_row_reg == LAST_GROUP);
        end else if (fill_active_reg && slot_free) begin
            m_data_reg  <= '0;
            m_index_reg <= fill_k_reg;
            m_page_reg  <= fill_page_reg;
            m_last_reg  <= (fill_k_reg == LAST_GROUP);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_page_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_input_during_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_active_reg |-> !s_tready)
        else $error("input request taken while zero groups are pending");

    a_fill_index_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_active_reg |-> (fill_k_reg != '0))
        else $error("zero-fill sequencer started at group zero");

    a_finished_at_page_start: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |-> (row_in_page_reg == '0) && (byte_in_row_reg == '0))
        else $error("finished with a partial row or page");

    a_page_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        page_count_reg <= PCOUNT_W'(8))
        else $error("page count beyond the page limit range");

    a_fill_ends_page: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_active_reg && slot_free && (fill_k_reg == LAST_GROUP)) |=>
            m_valid_reg && m_last_reg && !fill_active_reg)
        else $error("final zero group did not close the page");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Testbench for the bitmap row to display page transposer.
//
// Pixel bytes go in on the s_ stream in bursts with random gaps, and column groups come back
// on the m_ stream while the receiver stalls on a pattern of its own. Every accepted pixel
// request runs through a local predictor that keeps its own copy of the row store, the
// counters and the registers. Whatever column groups that request should cause are queued,
// and every column group that the block hands over is checked field by field against the
// oldest one in the queue.
//
// There is only one reset, so the whole run is a single image of at most eight pages. Once
// the image is complete, the block drops all further input. The run therefore walks through
// the image piece by piece and changes the registers between pieces, always while the block
// is idle.
module tb;
    import brop_pkg::*;

    localparam int  ITEMS_TARGET     = 110;
    localparam int  LONG_HOLD_CYCLES = 300;
    localparam int  SETTLE_CYCLES    = 4;
    localparam int  TAIL_CYCLES      = 20;
    localparam int  PRINT_LIMIT      = 40;
    localparam int  DIRECTED_STEPS   = 27;

    typedef struct packed {
        logic [GROUP_W-1:0] columns;
        logic [INDEX_W-1:0] group;
        logic [PAGE_W-1:0]  page;
        logic               last;
    } column_group_t;

    typedef enum logic {STEP_REGISTER, STEP_PIXEL} step_kind_t;

    // One row of the directed part. A register row uses reg_index and value. A pixel row
    // sends value[7:0], and where typed is set, the first column group that this request
    // causes must equal typed_columns.
    typedef struct packed {
        step_kind_t         kind;
        logic [1:0]         reg_index;
        logic [31:0]        value;
        logic               typed;
        logic [GROUP_W-1:0] typed_columns;
    } directed_step_t;

    typedef enum int {SINK_ALWAYS, SINK_HALF, SINK_RARE, SINK_MOSTLY} sink_mode_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [7:0]              s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [63:0]             m_tdata;
    logic [6:0]              m_tuser;
    logic                    m_tlast;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    bitmap_rows_to_oled_pages_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Column groups that the block still owes us, oldest first.
    column_group_t pending_column_groups[$];

    // The predictor's copy of the registers and of the block's state.
    logic [RB_W-1:0]     cfg_row_bytes;
    logic [IH_W-1:0]     cfg_image_height;
    logic [PL_W-1:0]     cfg_page_limit;
    logic [PAGE_W-1:0]   cfg_start_page;
    logic [STORE_W-1:0]  held_rows [NUM_GROUPS];
    logic [ROW_W-1:0]    row_slot;
    logic [INDEX_W-1:0]  byte_slot;
    logic [PCOUNT_W-1:0] pages_sent;
    logic [IH_W-1:0]     rows_taken;
    logic                image_complete;

    int mismatches;
    int burst_left;
    bit long_hold_armed;

    directed_step_t directed_steps [DIRECTED_STEPS];

    // Clock: 8 ns period.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t: mismatch in %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Row r of the page sits in bits 8r+7..8r; its leftmost pixel (bit 7) belongs to column 0.
    // Column x collects pixel x of every row, with row 0 in its top bit.
    function automatic logic [GROUP_W-1:0] columns_of_rows(input logic [GROUP_W-1:0] rows);
        logic [GROUP_W-1:0] cols;
        logic [7:0]         row_pixels;
        cols = '0;
        for (int r = 0; r < 8; r++) begin
            row_pixels = rows[8*r +: 8];
            for (int x = 0; x < 8; x++)
                cols[8*x + 7 - r] = row_pixels[7 - x];
        end
        return cols;
    endfunction

    function automatic void queue_column_group(input logic [GROUP_W-1:0] cols, input int k,
                                               input logic last);
        column_group_t grp;
        grp.columns = cols;
        grp.group   = INDEX_W'(k);
        grp.page    = cfg_start_page - pages_sent[PAGE_W-1:0];
        grp.last    = last;
        pending_column_groups.push_back(grp);
    endfunction

    // Advances the predictor by one accepted pixel byte. Returns the number of column groups
    // that it causes, or -1 when the block must drop the byte.
    function automatic int transpose_pixel_byte(input logic [7:0] px);
        int                 rb;
        int                 ih;
        int                 pl;
        int                 produced;
        int                 bi;
        logic               row_end;
        logic               last_row;
        logic               flush;
        logic [GROUP_W-1:0] rows;

        // Out-of-range register values saturate into their legal ranges.
        rb = (cfg_row_bytes == 0) ? 1 : (cfg_row_bytes > NUM_GROUPS) ? NUM_GROUPS
                                                                        : int'(cfg_row_bytes);
        ih = (cfg_image_height == 0) ? 1 : (cfg_image_height > 64) ? 64
                                                                      : int'(cfg_image_height);
        pl = (cfg_page_limit == 0) ? 1 : (cfg_page_limit > 8) ? 8 : int'(cfg_page_limit);

        if (image_complete || int'(pages_sent) >= pl)
            return -1;

        produced = 0;
        bi       = int'(byte_slot);
        row_end  = (bi >= rb - 1);
        last_row = (int'(rows_taken) + 1 >= ih);
        flush    = (row_slot == ROW_W'(PAGE_ROWS - 1)) || last_row;

        if (flush) begin
            // Rows that never arrived in this page stay zero.
            rows = {8'h00, held_rows[bi]} | (GROUP_W'(px) << (8 * row_slot));
            queue_column_group(columns_of_rows(rows), bi, row_end && bi == NUM_GROUPS - 1);
            produced++;
            if (row_end) begin
                for (int k = bi + 1; k < NUM_GROUPS; k++) begin
                    queue_column_group('0, k, k == NUM_GROUPS - 1);
                    produced++;
                end
            end
        end else begin
            held_rows[bi] = held_rows[bi] | (STORE_W'(px) << (8 * row_slot));
        end

        if (row_end) begin
            byte_slot  = '0;
            rows_taken = rows_taken + IH_W'(1);
            if (flush) begin
                foreach (held_rows[i])
                    held_rows[i] = '0;
                row_slot   = '0;
                pages_sent = pages_sent + PCOUNT_W'(1);
                if (last_row || int'(pages_sent) >= pl)
                    image_complete = 1'b1;
            end else begin
                row_slot = row_slot + ROW_W'(1);
            end
        end else begin
            byte_slot = INDEX_W'(bi + 1);
        end
        return produced;
    endfunction

    // Offers one pixel byte and returns once the block has taken it. The sender runs in
    // bursts: when a burst is used up, a new length is drawn and usually a gap is left.
    task automatic send_pixel(input logic [7:0] px, input logic typed,
                              input logic [GROUP_W-1:0] typed_columns, output int produced);
        int base;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        base     = pending_column_groups.size();
        produced = transpose_pixel_byte(px);
        if (typed && produced > 0)
            pending_column_groups[base].columns = typed_columns;
    endtask

    // Stops offering requests and waits until the block has handed over every column group,
    // then lets the block settle in case it is still storing a byte that causes no result.
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_column_groups.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the edge that ends
    // the access cycle.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROW_BYTES:    cfg_row_bytes    = word[RB_W-1:0];
            REG_IMAGE_HEIGHT: cfg_image_height = word[IH_W-1:0];
            REG_PAGE_LIMIT:   cfg_page_limit   = word[PL_W-1:0];
            REG_START_PAGE:   cfg_start_page   = word[PAGE_W-1:0];
            default: ;
        endcase
    endtask

    // The receiver: stretches of random length, each with its own stall pattern. Once the
    // main sequence arms it, it holds off for a long stretch while column groups are owed,
    // so that the output fills up and the block has to stall its input.
    initial begin : result_sink
        int         stretch;
        sink_mode_t mode;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            mode    = sink_mode_t'($urandom_range(0, 3));
            stretch = $urandom_range(4, 40);
            repeat (stretch) begin
                @(posedge aclk);
                case (mode)
                    SINK_ALWAYS: m_tready <= 1'b1;
                    SINK_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
                    SINK_RARE:   m_tready <= ($urandom_range(0, 3) == 0);
                    default:     m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
            if (long_hold_armed && pending_column_groups.size() > 0) begin
                long_hold_armed = 1'b0;
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            end
        end
    end

    // Every column group handed over is compared with the oldest one still owed.
    always @(posedge aclk) begin : result_check
        column_group_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_column_groups.size() == 0) begin
                report_mismatch("column group with none owed", m_tdata, '0);
            end else begin
                want = pending_column_groups.pop_front();
                if (m_tdata !== want.columns)
                    report_mismatch("column_group", m_tdata, want.columns);
                if (m_tuser[3:0] !== want.group)
                    report_mismatch("group_index", 64'(m_tuser[3:0]), 64'(want.group));
                if (m_tuser[6:4] !== want.page)
                    report_mismatch("page", 64'(m_tuser[6:4]), 64'(want.page));
                if (m_tlast !== want.last)
                    report_mismatch("page_last", 64'(m_tlast), 64'(want.last));
            end
        end
    end

    initial begin : main_sequence
        int          produced;
        int          random_items;
        int          segment_len;
        logic [31:0] word;
        logic [7:0]  px;
        bit          set_rb;
        bit          set_sp;
        bit          set_pl;
        bit          set_ih;

        // Every input known from the first instant.
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        mismatches      = 0;
        burst_left      = 0;
        random_items    = 0;
        long_hold_armed = 1'b0;

        // The predictor starts from the reset state.
        cfg_row_bytes    = ROW_BYTES_RESET;
        cfg_image_height = IMAGE_HEIGHT_RESET;
        cfg_page_limit   = PAGE_LIMIT_RESET;
        cfg_start_page   = START_PAGE_RESET;
        foreach (held_rows[i])
            held_rows[i] = '0;
        row_slot       = '0;
        byte_slot      = '0;
        pages_sent     = '0;
        rows_taken     = '0;
        image_complete = 1'b0;

        // Directed part.
        // Page 0 with a row width of zero, which saturates to one byte: a diagonal line whose
        // transposed group is easy to read off, then fifteen zero-fill groups on page 7.
        // Then a page limit of zero, which saturates to one page and makes the block drop
        // bytes; a limit of 15 saturates to eight and lets input through again.
        // Page 1 numbers downward from start page 0, so it wraps to page 7. The closing row
        // widens to three bytes and narrows back to one in the middle of the row, so its
        // third byte ends it.
        directed_steps = '{
            '{STEP_REGISTER, REG_ROW_BYTES,    32'd0,   1'b0, 64'h0},
            '{STEP_REGISTER, REG_IMAGE_HEIGHT, 32'd127, 1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'h80,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'h40,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'h20,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'h10,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'h08,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'h04,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'h02,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'h01,  1'b1, 64'h0102_0408_1020_4080},
            '{STEP_REGISTER, REG_PAGE_LIMIT,   32'd0,   1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'hFF,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'h00,  1'b0, 64'h0},
            '{STEP_REGISTER, REG_PAGE_LIMIT,   32'd15,  1'b0, 64'h0},
            '{STEP_REGISTER, REG_START_PAGE,   32'd0,   1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'hFF,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'hFF,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'hFF,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'hFF,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'hFF,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'hFF,  1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'hFF,  1'b0, 64'h0},
            '{STEP_REGISTER, REG_ROW_BYTES,    32'd3,   1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'hFF,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
            '{STEP_PIXEL,    2'b00,            32'h00,  1'b1, 64'h0},
            '{STEP_REGISTER, REG_ROW_BYTES,    32'd1,   1'b0, 64'h0},
            '{STEP_PIXEL,    2'b00,            32'h5A,  1'b0, 64'h0}
        };

        // Reset is held low and released at a rising edge.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_REGISTER) begin
                wait_idle();
                write_register(directed_steps[i].reg_index, directed_steps[i].value);
            end else begin
                send_pixel(directed_steps[i].value[7:0], directed_steps[i].typed,
                           directed_steps[i].typed_columns, produced);
            end
        end

        // Random part: segments of random pixel bytes. Before a segment, the registers may
        // change; upper bits of the write data are junk that the block must drop. Segments end
        // anywhere in a row, so row width changes also land in the middle of rows.
        long_hold_armed = 1'b1;
        while (random_items < ITEMS_TARGET && !image_complete) begin
            set_rb = ($urandom_range(0, 2) != 0);
            set_sp = ($urandom_range(0, 9) < 3);
            set_pl = ($urandom_range(0, 9) == 0);
            set_ih = ($urandom_range(0, 9) == 0);
            if (set_rb || set_sp || set_pl || set_ih)
                wait_idle();
            if (set_rb) begin
                word = $urandom();
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
                        word[RB_W-1:0] = RB_W'($urandom_range(1, 3));
                    12, 13, 14, 15:
                        word[RB_W-1:0] = RB_W'($urandom_range(4, 8));
                    16, 17:
                        word[RB_W-1:0] = RB_W'($urandom_range(9, 16));
                    18:
                        word[RB_W-1:0] = '0;
                    default:
                        word[RB_W-1:0] = RB_W'($urandom_range(17, 31));
                endcase
                write_register(REG_ROW_BYTES, word);
            end
            if (set_sp)
                write_register(REG_START_PAGE, $urandom());
            if (set_pl) begin
                word = $urandom();
                word[PL_W-1:0] = PL_W'($urandom_range(8, 15));
                write_register(REG_PAGE_LIMIT, word);
            end
            if (set_ih) begin
                word = $urandom();
                word[IH_W-1:0] = IH_W'($urandom_range(64, 127));
                write_register(REG_IMAGE_HEIGHT, word);
            end
            segment_len = $urandom_range(1, 12);
            repeat (segment_len) begin
                case ($urandom_range(0, 9))
                    0:       px = 8'h00;
                    1:       px = 8'hFF;
                    default: px = 8'($urandom_range(0, 255));
                endcase
                send_pixel(px, 1'b0, '0, produced);
                if (produced >= 0)
                    random_items++;
            end
        end

        // Closing the image: a short height, or zero, which saturates to one, makes the next
        // row or one a few rows on the last image row. Its page is flushed early, with the
        // missing rows read as zero.
        if (!image_complete) begin
            wait_idle();
            word = $urandom();
            if ($urandom_range(0, 3) == 0)
                word[IH_W-1:0] = '0;
            else
                word[IH_W-1:0] = rows_taken + IH_W'($urandom_range(1, 7));
            write_register(REG_IMAGE_HEIGHT, word);
        end
        while (!image_complete)
            send_pixel(8'($urandom_range(0, 255)), 1'b0, '0, produced);

        // Bytes after the end of the image must vanish without a result.
        repeat (4)
            send_pixel(8'($urandom_range(0, 255)), 1'b0, '0, produced);

        s_tvalid <= 1'b0;
        while (pending_column_groups.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_column_groups.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/brop_pkg.sv
design/bitmap_rows_to_oled_pages_top.sv
tb/tb.sv
